// File: src/ffpa_pkg.sv
package ffpa_pkg;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_PAGE  = 2'd2
  } status_e;

  // request sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // retire threshold after reset
  localparam int unsigned RetireThreshReset = 64;

endpackage

// File: src/ffpa_page_ram.sv
module ffpa_page_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/first_fit_page_bump_allocator.sv
// First-fit page bump allocator.
// Input channel (in_valid_i / in_ready_o) carries one request beat, a byte count.
// Output channel (out_valid_o / out_ready_i) returns one result beat per request:
// the page, the start offset in it, whether a page was opened, and a status.
// retire_threshold_i is written whenever cfg_we_i is high; write it only while idle.
// Each page table entry holds the fill level and two retire marks; all of it sits
// in one synchronous ram with a single read port, walked once per request of at most PAGE_BYTES.
// The input beat starts a walk over the ram read port, one entry per cycle over the
// opened pages; an oversize request skips the walk and goes straight to the result.
// After the last read returns, the result is loaded into the output register, and
// the next request is taken in the cycle after that, so the block takes no new
// request before it is through with the walk of the last one.
// A new request is taken once the previous result sits in the output register,
// so a waiting result does not block the next walk; a stalled receiver holds the
// result steady and the block waits before loading the next one.
// Reset empties the page table (no pages open) and loads the threshold with 64.
// No clearing pass is needed: only entries of opened pages are ever read.
module first_fit_page_bump_allocator #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_PAGES  = 64,
  localparam int unsigned ReqW = $clog2(PAGE_BYTES + 1),
  localparam int unsigned OfsW = $clog2(PAGE_BYTES),
  localparam int unsigned IdxW = $clog2(MAX_PAGES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic [ReqW-1:0]  retire_threshold_i,
  // request channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ReqW-1:0]  request_bytes_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  page_index_o,
  output logic [OfsW-1:0]  byte_offset_o,
  output logic             opened_page_o,
  output ffpa_pkg::status_e status_o
);

  import ffpa_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAGES + 1);
  // entry layout: {fill, committed retire, tentative retire}
  localparam int unsigned EntW = ReqW + 2;

  state_e            state_q, state_d;
  logic [ReqW-1:0]   thresh_q, thresh_d;
  logic [CntW-1:0]   pages_open_q, pages_open_d;
  logic              commit_q, commit_d;   // last walk was committed
  logic [CntW-1:0]   rd_cnt_q, rd_cnt_d;
  logic              rvalid_q, rvalid_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic              found_q, found_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic [OfsW-1:0]   hit_ofs_q, hit_ofs_d;
  logic [ReqW-1:0]   req_q, req_d;
  logic              too_big_q, too_big_d;

  logic              out_valid_q, out_valid_d;
  logic [IdxW-1:0]   page_q, page_d;
  logic [OfsW-1:0]   ofs_q, ofs_d;
  logic              opened_q, opened_d;
  status_e           status_q, status_d;

  // page table port signals
  logic              mem_we;
  logic [IdxW-1:0]   mem_waddr;
  logic [EntW-1:0]   mem_wdata;
  logic              mem_re;
  logic [IdxW-1:0]   mem_raddr;
  logic [EntW-1:0]   mem_rdata;

  // entry evaluation
  logic [ReqW-1:0]   rd_fill;
  logic              eff_ret;
  logic [ReqW-1:0]   room;
  logic              retire_nx;
  logic              fits;
  logic              hit;
  logic [ReqW-1:0]   new_fill;
  logic              out_free;

  ffpa_page_ram #(
    .Depth (MAX_PAGES),
    .Width (EntW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // the retire decisions of a walk only become real once the walk commits:
  // committed mark is valid if the last walk was dropped, tentative otherwise
  assign rd_fill   = mem_rdata[EntW-1:2];
  assign eff_ret   = commit_q ? mem_rdata[0] : mem_rdata[1];
  assign room      = ReqW'(PAGE_BYTES) - rd_fill;
  assign retire_nx = eff_ret || (room == '0) || (room < thresh_q);
  assign fits      = !retire_nx && (room >= req_q);
  assign hit       = rvalid_q && fits && !found_q;
  assign new_fill  = hit ? (rd_fill + req_q) : rd_fill;

  assign mem_re    = (state_q == S_SCAN) && (rd_cnt_q < pages_open_q);
  assign mem_raddr = rd_cnt_q[IdxW-1:0];

  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    thresh_d     = cfg_we_i ? retire_threshold_i : thresh_q;
    pages_open_d = pages_open_q;
    commit_d     = commit_q;
    rd_cnt_d     = rd_cnt_q;
    rvalid_d     = mem_re;
    rd_idx_d     = rd_cnt_q[IdxW-1:0];
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_ofs_d    = hit_ofs_q;
    req_d        = req_q;
    too_big_d    = too_big_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    page_d       = page_q;
    ofs_d        = ofs_q;
    opened_d     = opened_q;
    status_d     = status_q;
    mem_we       = 1'b0;
    mem_waddr    = rd_idx_q;
    mem_wdata    = {new_fill, eff_ret, retire_nx};
    in_ready_o   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d     = request_bytes_i;
          too_big_d = (request_bytes_i > ReqW'(PAGE_BYTES));
          rd_cnt_d  = '0;
          found_d   = 1'b0;
          state_d   = (request_bytes_i > ReqW'(PAGE_BYTES)) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (mem_re) begin
          rd_cnt_d = rd_cnt_q + 1'b1;
        end
        // every opened entry is rewritten with its fresh retire marks
        if (rvalid_q) begin
          mem_we = 1'b1;
          if (hit) begin
            found_d   = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_ofs_d = rd_fill[OfsW-1:0];
          end
        end
        if (!mem_re && !rvalid_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          page_d      = '0;
          ofs_d       = '0;
          opened_d    = 1'b0;
          if (too_big_q) begin
            status_d = ST_TOO_BIG;
          end else if (found_q) begin
            status_d = ST_OK;
            page_d   = hit_idx_q;
            ofs_d    = hit_ofs_q;
            commit_d = 1'b1;
          end else if (pages_open_q == CntW'(MAX_PAGES)) begin
            // drop the retire decisions of this walk
            status_d = ST_NO_PAGE;
            commit_d = 1'b0;
          end else begin
            // open the next page
            status_d     = ST_OK;
            page_d       = pages_open_q[IdxW-1:0];
            opened_d     = 1'b1;
            commit_d     = 1'b1;
            pages_open_d = pages_open_q + 1'b1;
            mem_we       = 1'b1;
            mem_waddr    = pages_open_q[IdxW-1:0];
            mem_wdata    = {req_q, 2'b00};
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thresh_q     <= ReqW'(RetireThreshReset);
      pages_open_q <= '0;
      commit_q     <= 1'b1;
      rd_cnt_q     <= '0;
      rvalid_q     <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      thresh_q     <= thresh_d;
      pages_open_q <= pages_open_d;
      commit_q     <= commit_d;
      rd_cnt_q     <= rd_cnt_d;
      rvalid_q     <= rvalid_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    hit_idx_q <= hit_idx_d;
    hit_ofs_q <= hit_ofs_d;
    req_q     <= req_d;
    too_big_q <= too_big_d;
    page_q    <= page_d;
    ofs_q     <= ofs_d;
    opened_q  <= opened_d;
    status_q  <= status_d;
  end

  assign out_valid_o   = out_valid_q;
  assign page_index_o  = page_q;
  assign byte_offset_o = ofs_q;
  assign opened_page_o = opened_q;
  assign status_o      = status_q;

`ifndef SYNTHESIS
  // the walk never reads the entry it is writing back
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_re && mem_we) |-> (mem_raddr != mem_waddr))
    else $error("page table read and write hit the same entry");

  a_pages_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_open_q <= CntW'(MAX_PAGES))
    else $error("open page count beyond table depth");

  a_pages_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pages_open_q != $past(pages_open_q)) |->
      (pages_open_q == CntW'($past(pages_open_q) + 1'b1)))
    else $error("open page count moved by more than one");

  a_open_is_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && opened_page_o) |-> (status_o == ST_OK))
    else $error("page opened on a failed request");

  a_error_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (too_big_q || (!found_q &&
      pages_open_q == CntW'(MAX_PAGES)))) |-> !mem_we)
    else $error("page table written on a failed request");
`endif

endmodule
